[rtl/core/fbc_pkg.sv]
// shared types, constants and codes of the frustum box cull block
package fbc_pkg;

    localparam int unsigned PLANE_COUNT_DEF = 6;
    localparam int unsigned PLANE_COUNT_MAX = 8;
    localparam int unsigned SLOT_W = 3;
    localparam int unsigned COORD_W = 24;
    localparam int unsigned OFFSET_W = 48;
    localparam int unsigned PROD_W = 2 * COORD_W;
    localparam int unsigned DOT_W = OFFSET_W + 2;
    localparam int unsigned CFG_INDEX_W = 3;

    localparam logic FUNC_TEST = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_SKIP_NEAR = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_VIEW_MIN_X = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VIEW_MIN_Y = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_VIEW_MIN_Z = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_VIEW_MAX_X = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_VIEW_MAX_Y = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_VIEW_MAX_Z = 3'd6;

    typedef enum logic [1:0] {
        CAUSE_VISIBLE = 2'd0,
        CAUSE_CAMERA  = 2'd1,
        CAUSE_PLANE   = 2'd2
    } cull_cause_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] lo_x;
        logic signed [COORD_W-1:0] lo_y;
        logic signed [COORD_W-1:0] lo_z;
        logic signed [COORD_W-1:0] hi_x;
        logic signed [COORD_W-1:0] hi_y;
        logic signed [COORD_W-1:0] hi_z;
    } box_t;

    typedef struct packed {
        cull_cause_t       cause;
        logic [SLOT_W-1:0] plane;
        box_t              box;
    } token_t;

    typedef struct packed {
        logic                       en;
        logic [SLOT_W-1:0]          slot;
        logic signed [COORD_W-1:0]  a;
        logic signed [COORD_W-1:0]  b;
        logic signed [COORD_W-1:0]  c;
        logic signed [OFFSET_W-1:0] d;
    } plane_wr_t;

endpackage

[rtl/core/fbc_cell.sv]
// one plane cell: holds a plane entry and tests the passing box against it
module fbc_cell #(
    parameter int unsigned CELL_INDEX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fbc_pkg::plane_wr_t plane_wr,
    input  logic               skip_near,
    input  logic               tok_in_valid,
    input  fbc_pkg::token_t    tok_in,
    output logic               tok_out_valid,
    output fbc_pkg::token_t    tok_out
);

    localparam logic [fbc_pkg::SLOT_W-1:0] CELL_SLOT = fbc_pkg::SLOT_W'(CELL_INDEX);

    logic signed [fbc_pkg::COORD_W-1:0]  a_reg;
    logic signed [fbc_pkg::COORD_W-1:0]  b_reg;
    logic signed [fbc_pkg::COORD_W-1:0]  c_reg;
    logic signed [fbc_pkg::OFFSET_W-1:0] d_reg;

    logic signed [fbc_pkg::COORD_W-1:0] x_sel;
    logic signed [fbc_pkg::COORD_W-1:0] y_sel;
    logic signed [fbc_pkg::COORD_W-1:0] z_sel;

    logic signed [fbc_pkg::PROD_W-1:0] px_reg;
    logic signed [fbc_pkg::PROD_W-1:0] py_reg;
    logic signed [fbc_pkg::PROD_W-1:0] pz_reg;
    logic signed [fbc_pkg::PROD_W-1:0] px_next;
    logic signed [fbc_pkg::PROD_W-1:0] py_next;
    logic signed [fbc_pkg::PROD_W-1:0] pz_next;
    logic                              mid_valid_reg;
    fbc_pkg::token_t                   mid_tok_reg;

    logic signed [fbc_pkg::DOT_W-1:0] dot;
    logic                             cell_live;
    logic                             out_valid_reg;
    fbc_pkg::token_t                  out_tok_reg;
    fbc_pkg::token_t                  out_tok_next;

    // plane entry, undefined until loaded
    always_ff @(posedge clk)
    begin
        if (plane_wr.en && (plane_wr.slot == CELL_SLOT))
        begin
            a_reg <= plane_wr.a;
            b_reg <= plane_wr.b;
            c_reg <= plane_wr.c;
            d_reg <= plane_wr.d;
        end
    end

    // corner with the largest dot product, per axis
    always_comb
    begin
        x_sel = ((!a_reg[fbc_pkg::COORD_W-1]) == (tok_in.box.hi_x >= tok_in.box.lo_x))
              ? tok_in.box.hi_x : tok_in.box.lo_x;
        y_sel = ((!b_reg[fbc_pkg::COORD_W-1]) == (tok_in.box.hi_y >= tok_in.box.lo_y))
              ? tok_in.box.hi_y : tok_in.box.lo_y;
        z_sel = ((!c_reg[fbc_pkg::COORD_W-1]) == (tok_in.box.hi_z >= tok_in.box.lo_z))
              ? tok_in.box.hi_z : tok_in.box.lo_z;
        px_next = a_reg * x_sel;
        py_next = b_reg * y_sel;
        pz_next = c_reg * z_sel;
    end

    always_ff @(posedge clk)
    begin
        px_reg      <= px_next;
        py_reg      <= py_next;
        pz_reg      <= pz_next;
        mid_tok_reg <= tok_in;
    end

    assign cell_live = !(skip_near && (CELL_INDEX == 0));

    always_comb
    begin
        dot = fbc_pkg::DOT_W'(px_reg) + fbc_pkg::DOT_W'(py_reg)
            + fbc_pkg::DOT_W'(pz_reg) + fbc_pkg::DOT_W'(d_reg);
        out_tok_next = mid_tok_reg;
        if (cell_live && (mid_tok_reg.cause == fbc_pkg::CAUSE_VISIBLE)
            && dot[fbc_pkg::DOT_W-1])
        begin
            out_tok_next.cause = fbc_pkg::CAUSE_PLANE;
            out_tok_next.plane = CELL_SLOT;
        end
    end

    always_ff @(posedge clk)
    begin
        out_tok_reg <= out_tok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mid_valid_reg <= tok_in_valid;
            out_valid_reg <= mid_valid_reg;
        end
    end

    assign tok_out_valid = out_valid_reg;
    assign tok_out       = out_tok_reg;

endmodule

[rtl/core/frustum_box_cull_top.sv]
// top level of the frustum box cull block: camera box check, plane cell chain, result register
// A load transaction (func 1) writes one plane entry and gives no result;
// a slot of PLANE_COUNT or more is ignored. A test transaction (func 0) first checks the box
// against the camera box, then travels down a chain of PLANE_COUNT cells, one per plane entry,
// each registering its three products, then the sum and sign test. The block holds one
// test at a time: the result is offered after the test passes the head register, the cells
// and the result register, and the next transaction is taken in the cycle after the result is taken.
// Planes are stored in the cells without reset; test only after every used entry is loaded.
// Configuration writes are always ready and must be made while no test is in flight.
module frustum_box_cull_top #(
    parameter int unsigned PLANE_COUNT = fbc_pkg::PLANE_COUNT_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  logic                                  func,
    input  logic [fbc_pkg::SLOT_W-1:0]            plane_slot,
    input  logic signed [fbc_pkg::COORD_W-1:0]    normal_a,
    input  logic signed [fbc_pkg::COORD_W-1:0]    normal_b,
    input  logic signed [fbc_pkg::COORD_W-1:0]    normal_c,
    input  logic signed [fbc_pkg::OFFSET_W-1:0]   offset_d,
    input  logic signed [fbc_pkg::COORD_W-1:0]    lo_x,
    input  logic signed [fbc_pkg::COORD_W-1:0]    lo_y,
    input  logic signed [fbc_pkg::COORD_W-1:0]    lo_z,
    input  logic signed [fbc_pkg::COORD_W-1:0]    hi_x,
    input  logic signed [fbc_pkg::COORD_W-1:0]    hi_y,
    input  logic signed [fbc_pkg::COORD_W-1:0]    hi_z,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic                                  culled,
    output logic [1:0]                            cull_cause,
    output logic [fbc_pkg::SLOT_W-1:0]            rejecting_plane,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fbc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [fbc_pkg::COORD_W-1:0]           cfg_data
);

    logic                               skip_near_reg;
    logic signed [fbc_pkg::COORD_W-1:0] view_min_x_reg;
    logic signed [fbc_pkg::COORD_W-1:0] view_min_y_reg;
    logic signed [fbc_pkg::COORD_W-1:0] view_min_z_reg;
    logic signed [fbc_pkg::COORD_W-1:0] view_max_x_reg;
    logic signed [fbc_pkg::COORD_W-1:0] view_max_y_reg;
    logic signed [fbc_pkg::COORD_W-1:0] view_max_z_reg;

    logic                 item_fire;
    logic                 test_fire;
    logic                 result_fire;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 overlap;
    fbc_pkg::plane_wr_t   plane_wr;
    fbc_pkg::token_t      head_tok_next;
    logic                 head_valid_reg;
    fbc_pkg::token_t      head_tok_reg;

    logic [PLANE_COUNT:0] tok_valid;
    fbc_pkg::token_t      tok [PLANE_COUNT+1];

    logic                       res_valid_reg;
    logic                       res_valid_next;
    fbc_pkg::cull_cause_t       res_cause_reg;
    logic [fbc_pkg::SLOT_W-1:0] res_plane_reg;

    assign cfg_ready   = 1'b1;
    assign item_ready  = !busy_reg;
    assign item_fire   = item_valid && item_ready;
    assign test_fire   = item_fire && (func == fbc_pkg::FUNC_TEST);
    assign result_fire = res_valid_reg && result_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_near_reg  <= 1'b0;
            view_min_x_reg <= '0;
            view_min_y_reg <= '0;
            view_min_z_reg <= '0;
            view_max_x_reg <= '0;
            view_max_y_reg <= '0;
            view_max_z_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fbc_pkg::REG_SKIP_NEAR:  skip_near_reg  <= cfg_data[0];
                fbc_pkg::REG_VIEW_MIN_X: view_min_x_reg <= cfg_data;
                fbc_pkg::REG_VIEW_MIN_Y: view_min_y_reg <= cfg_data;
                fbc_pkg::REG_VIEW_MIN_Z: view_min_z_reg <= cfg_data;
                fbc_pkg::REG_VIEW_MAX_X: view_max_x_reg <= cfg_data;
                fbc_pkg::REG_VIEW_MAX_Y: view_max_y_reg <= cfg_data;
                fbc_pkg::REG_VIEW_MAX_Z: view_max_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        plane_wr.en   = item_fire && (func == fbc_pkg::FUNC_LOAD);
        plane_wr.slot = plane_slot;
        plane_wr.a    = normal_a;
        plane_wr.b    = normal_b;
        plane_wr.c    = normal_c;
        plane_wr.d    = offset_d;
    end

    // camera box overlap, inclusive
    assign overlap = (view_min_x_reg <= hi_x) && (view_min_y_reg <= hi_y)
                  && (view_min_z_reg <= hi_z) && (view_max_x_reg >= lo_x)
                  && (view_max_y_reg >= lo_y) && (view_max_z_reg >= lo_z);

    always_comb
    begin
        head_tok_next.cause    = overlap ? fbc_pkg::CAUSE_VISIBLE : fbc_pkg::CAUSE_CAMERA;
        head_tok_next.plane    = '0;
        head_tok_next.box.lo_x = lo_x;
        head_tok_next.box.lo_y = lo_y;
        head_tok_next.box.lo_z = lo_z;
        head_tok_next.box.hi_x = hi_x;
        head_tok_next.box.hi_y = hi_y;
        head_tok_next.box.hi_z = hi_z;
    end

    always_ff @(posedge clk)
    begin
        if (test_fire)
        begin
            head_tok_reg <= head_tok_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= test_fire;
        end
    end

    assign tok_valid[0] = head_valid_reg;
    assign tok[0]       = head_tok_reg;

    for (genvar gi = 0; gi < PLANE_COUNT; gi++)
    begin : g_cell
        fbc_cell #(
            .CELL_INDEX(gi)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .plane_wr     (plane_wr),
            .skip_near    (skip_near_reg),
            .tok_in_valid (tok_valid[gi]),
            .tok_in       (tok[gi]),
            .tok_out_valid(tok_valid[gi+1]),
            .tok_out      (tok[gi+1])
        );
    end

    // result register and occupancy
    always_comb
    begin
        busy_next      = busy_reg;
        res_valid_next = res_valid_reg;
        if (test_fire)
        begin
            busy_next = 1'b1;
        end
        if (tok_valid[PLANE_COUNT])
        begin
            res_valid_next = 1'b1;
        end
        if (result_fire)
        begin
            busy_next      = 1'b0;
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_valid[PLANE_COUNT])
        begin
            res_cause_reg <= tok[PLANE_COUNT].cause;
            res_plane_reg <= tok[PLANE_COUNT].plane;
        end
    end

    assign result_valid    = res_valid_reg;
    assign culled          = (res_cause_reg != fbc_pkg::CAUSE_VISIBLE);
    assign cull_cause      = res_cause_reg;
    assign rejecting_plane = res_plane_reg;

    // at most one test valid at the head register, the cell outputs and the result register
    a_single_test: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({tok_valid, res_valid_reg}))
        else $error("more than one test in flight");

    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> busy_reg)
        else $error("result offered while not busy");

    a_tail_free: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid[PLANE_COUNT] |-> (busy_reg && !res_valid_reg))
        else $error("chain output with result register occupied");

    a_plane_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_cause_reg != fbc_pkg::CAUSE_PLANE)) |-> (res_plane_reg == '0))
        else $error("rejecting plane set without plane cause");

endmodule

[sim/frustum_box_cull_top_tb.sv]
// frustum_box_cull_top testbench: directed and random items, checked by predictor or typed verdict
`timescale 1ns / 1ps

module frustum_box_cull_top_tb;
    import fbc_pkg::*;

    localparam int PLANE_COUNT = PLANE_COUNT_DEF;
    localparam int CORNER_COUNT = 8;
    localparam int ITEMS_PER_PHASE = 583;
    localparam int SETTLE_CYCLES = 2 * PLANE_COUNT + 6;
    localparam int TAIL_CYCLES = 2 * PLANE_COUNT + 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT_RESULT = 300;
    localparam int HOLD_CYCLES = 400;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7fffff;
    localparam logic signed [OFFSET_W-1:0] OFFSET_MIN = 48'sh8000_0000_0000;
    localparam logic signed [OFFSET_W-1:0] OFFSET_MAX = 48'sh7fff_ffff_ffff;

    typedef struct packed {
        logic                       culled;
        cull_cause_t                cause;
        logic [SLOT_W-1:0]          plane;
    } verdict_t;

    localparam verdict_t VISIBLE_VERDICT = '{culled: 1'b0, cause: CAUSE_VISIBLE, plane: 3'd0};
    localparam verdict_t CAMERA_CULL = '{culled: 1'b1, cause: CAUSE_CAMERA, plane: 3'd0};

    typedef struct packed {
        logic                       func;
        logic [SLOT_W-1:0]          slot;
        logic signed [COORD_W-1:0]  a;
        logic signed [COORD_W-1:0]  b;
        logic signed [COORD_W-1:0]  c;
        logic signed [OFFSET_W-1:0] d;
        box_t                       box;
    } item_t;

    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_TEST,
        ROW_REG
    } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        item_t                  item;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [COORD_W-1:0]     reg_data;
        bit                     typed;
        verdict_t               typed_verdict;
    } stim_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       item_valid = 1'b0;
    logic                       item_ready;
    logic                       func = 1'b0;
    logic [SLOT_W-1:0]          plane_slot = '0;
    logic signed [COORD_W-1:0]  normal_a = '0;
    logic signed [COORD_W-1:0]  normal_b = '0;
    logic signed [COORD_W-1:0]  normal_c = '0;
    logic signed [OFFSET_W-1:0] offset_d = '0;
    logic signed [COORD_W-1:0]  lo_x = '0;
    logic signed [COORD_W-1:0]  lo_y = '0;
    logic signed [COORD_W-1:0]  lo_z = '0;
    logic signed [COORD_W-1:0]  hi_x = '0;
    logic signed [COORD_W-1:0]  hi_y = '0;
    logic signed [COORD_W-1:0]  hi_z = '0;
    logic                       result_valid;
    logic                       result_ready = 1'b0;
    logic                       culled;
    logic [1:0]                 cull_cause;
    logic [SLOT_W-1:0]          rejecting_plane;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [COORD_W-1:0]         cfg_data = '0;

    // predictor state
    logic signed [COORD_W-1:0]  plane_a [PLANE_COUNT];
    logic signed [COORD_W-1:0]  plane_b [PLANE_COUNT];
    logic signed [COORD_W-1:0]  plane_c [PLANE_COUNT];
    logic signed [OFFSET_W-1:0] plane_d [PLANE_COUNT];
    logic                       skip_near = 1'b0;
    logic signed [COORD_W-1:0]  view_lo [3] = '{default: '0};
    logic signed [COORD_W-1:0]  view_hi [3] = '{default: '0};

    verdict_t  pending_verdicts [$];
    stim_row_t directed_rows [$];
    int        mismatch_count = 0;
    int        item_idle_pct = 35;
    int        result_idle_pct = 49;

    frustum_box_cull_top DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
        begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    function automatic verdict_t predict_cull(input box_t bx);
        logic signed [COORD_W-1:0] lo [3];
        logic signed [COORD_W-1:0] hi [3];
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        longint                    dot;
        bit                        rejects;
        verdict_t                  v;
        int                        p;
        int                        k;
        lo[0] = bx.lo_x;
        lo[1] = bx.lo_y;
        lo[2] = bx.lo_z;
        hi[0] = bx.hi_x;
        hi[1] = bx.hi_y;
        hi[2] = bx.hi_z;
        for (p = 0; p < 3; p++)
        begin
            if (view_lo[p] > hi[p] || view_hi[p] < lo[p])
            begin
                return CAMERA_CULL;
            end
        end
        v = VISIBLE_VERDICT;
        for (p = skip_near ? 1 : 0; p < PLANE_COUNT; p++)
        begin
            rejects = 1'b1;
            for (k = 0; k < CORNER_COUNT; k++)
            begin
                x = (k & 1) ? hi[0] : lo[0];
                y = (k & 2) ? hi[1] : lo[1];
                z = (k & 4) ? hi[2] : lo[2];
                dot = longint'(plane_a[p]) * longint'(x) + longint'(plane_b[p]) * longint'(y)
                    + longint'(plane_c[p]) * longint'(z) + longint'(plane_d[p]);
                if (dot >= 0)
                begin
                    rejects = 1'b0;
                end
            end
            if (rejects)
            begin
                v.culled = 1'b1;
                v.cause = CAUSE_PLANE;
                v.plane = 3'(p);
                return v;
            end
        end
        return v;
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [COORD_W-1:0] data);
        case (idx)
            REG_SKIP_NEAR:  skip_near = data[0];
            REG_VIEW_MIN_X: view_lo[0] = data;
            REG_VIEW_MIN_Y: view_lo[1] = data;
            REG_VIEW_MIN_Z: view_lo[2] = data;
            REG_VIEW_MAX_X: view_hi[0] = data;
            REG_VIEW_MAX_Y: view_hi[1] = data;
            REG_VIEW_MAX_Z: view_hi[2] = data;
            default: ;
        endcase
    endfunction

    function automatic box_t make_box(input int lx, input int ly, input int lz,
                                      input int hx, input int hy, input int hz);
        box_t bx;
        bx.lo_x = lx[COORD_W-1:0];
        bx.lo_y = ly[COORD_W-1:0];
        bx.lo_z = lz[COORD_W-1:0];
        bx.hi_x = hx[COORD_W-1:0];
        bx.hi_y = hy[COORD_W-1:0];
        bx.hi_z = hz[COORD_W-1:0];
        return bx;
    endfunction

    function automatic box_t noise_box();
        return make_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_extreme();
        case ($urandom_range(3))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic box_t random_box();
        box_t bx;
        int   cx;
        int   cy;
        int   cz;
        case ($urandom_range(9))
            0, 1, 2, 3:
            begin
                cx = int'($urandom_range(131072)) - 65536;
                cy = int'($urandom_range(131072)) - 65536;
                cz = int'($urandom_range(131072)) - 65536;
                bx = make_box(cx - int'($urandom_range(4096)), cy - int'($urandom_range(4096)),
                              cz - int'($urandom_range(4096)), cx + int'($urandom_range(4096)),
                              cy + int'($urandom_range(4096)), cz + int'($urandom_range(4096)));
            end
            4, 5, 6: bx = noise_box();
            7, 8:
            begin
                bx = make_box(int'($urandom_range(128)) - 64, int'($urandom_range(128)) - 64,
                              int'($urandom_range(128)) - 64, int'($urandom_range(128)) - 64,
                              int'($urandom_range(128)) - 64, int'($urandom_range(128)) - 64);
            end
            default:
            begin
                bx.lo_x = pick_extreme();
                bx.lo_y = pick_extreme();
                bx.lo_z = pick_extreme();
                bx.hi_x = pick_extreme();
                bx.hi_y = pick_extreme();
                bx.hi_z = pick_extreme();
            end
        endcase
        return bx;
    endfunction

    function automatic item_t random_item();
        item_t it;
        it.slot = SLOT_W'($urandom);
        it.a = COORD_W'($urandom);
        it.b = COORD_W'($urandom);
        it.c = COORD_W'($urandom);
        it.d = OFFSET_W'({$urandom, $urandom});
        if ($urandom_range(99) < 12)
        begin
            it.func = FUNC_LOAD;
            it.box = noise_box();
            case ($urandom_range(3))
                0, 1:
                begin
                    it.a = COORD_W'(int'($urandom_range(32)) - 16);
                    it.b = COORD_W'(int'($urandom_range(32)) - 16);
                    it.c = COORD_W'(int'($urandom_range(32)) - 16);
                    it.d = OFFSET_W'(longint'($urandom_range(2097152)) - 1048576);
                end
                2: ;
                default:
                begin
                    case ($urandom_range(3))
                        0: it.d = '0;
                        1: it.d = OFFSET_MIN;
                        2: it.d = OFFSET_MAX;
                        default: it.d = '1;
                    endcase
                end
            endcase
        end
        else
        begin
            it.func = FUNC_TEST;
            it.box = random_box();
        end
        return it;
    endfunction

    function automatic void add_load(input int slot, input int a, input int b, input int c,
                                     input longint d);
        stim_row_t row;
        row.kind = ROW_LOAD;
        row.item.func = FUNC_LOAD;
        row.item.slot = slot[SLOT_W-1:0];
        row.item.a = a[COORD_W-1:0];
        row.item.b = b[COORD_W-1:0];
        row.item.c = c[COORD_W-1:0];
        row.item.d = d[OFFSET_W-1:0];
        row.item.box = noise_box();
        row.reg_index = '0;
        row.reg_data = '0;
        row.typed = 1'b0;
        row.typed_verdict = VISIBLE_VERDICT;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_test(input box_t bx, input bit typed, input verdict_t v);
        stim_row_t row;
        row.kind = ROW_TEST;
        row.item.func = FUNC_TEST;
        row.item.slot = SLOT_W'($urandom);
        row.item.a = COORD_W'($urandom);
        row.item.b = COORD_W'($urandom);
        row.item.c = COORD_W'($urandom);
        row.item.d = OFFSET_W'({$urandom, $urandom});
        row.item.box = bx;
        row.reg_index = '0;
        row.reg_data = '0;
        row.typed = typed;
        row.typed_verdict = v;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_reg(input logic [CFG_INDEX_W-1:0] idx, input int data);
        stim_row_t row;
        row.kind = ROW_REG;
        row.item = '0;
        row.reg_index = idx;
        row.reg_data = data[COORD_W-1:0];
        row.typed = 1'b0;
        row.typed_verdict = VISIBLE_VERDICT;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_camera(input int mn, input int mx);
        add_reg(REG_VIEW_MIN_X, mn);
        add_reg(REG_VIEW_MIN_Y, mn);
        add_reg(REG_VIEW_MIN_Z, mn);
        add_reg(REG_VIEW_MAX_X, mx);
        add_reg(REG_VIEW_MAX_Y, mx);
        add_reg(REG_VIEW_MAX_Z, mx);
    endfunction

    function automatic void build_directed_table();
        int mn;
        int mx;
        mn = int'(COORD_MIN);
        mx = int'(COORD_MAX);
        // reset camera box is the origin, so these are camera culled and no plane entry decides them
        add_test(make_box(1, 1, 1, 5, 5, 5), 1'b1, CAMERA_CULL);
        add_test(make_box(5, 5, 5, -5, -5, -5), 1'b1, CAMERA_CULL);
        add_load(0, 0, 0, 1, -1000);
        add_load(1, mn, mx, mn, longint'(OFFSET_MAX));
        add_load(2, mx, mn, mx, longint'(OFFSET_MIN));
        add_load(3, 1, 0, 0, 1000);
        add_load(4, 0, -1, 0, 1000);
        add_load(5, 0, 0, 0, 0);
        add_load(6, mn, mn, mn, longint'(OFFSET_MIN));
        add_load(7, mx, mx, mx, longint'(OFFSET_MAX));
        add_reg(REG_SKIP_NEAR, 0);
        add_camera(-100, 100);
        add_test(make_box(-200, -5, -5, -101, 5, 5), 1'b1, CAMERA_CULL);
        add_test(make_box(-200, -5, -5, -100, 5, 5), 1'b0, VISIBLE_VERDICT);
        add_test(make_box(-5, -5, 101, 5, 5, 200), 1'b1, CAMERA_CULL);
        add_test(make_box(100, 100, 100, 100, 100, 100), 1'b0, VISIBLE_VERDICT);
        add_camera(mn, mx);
        add_test(make_box(mn, mn, mn, mx, mx, mx), 1'b0, VISIBLE_VERDICT);
        add_test(make_box(mx, mx, mx, mx, mx, mx), 1'b0, VISIBLE_VERDICT);
        add_test(make_box(mn, mn, mn, mn, mn, mn), 1'b0, VISIBLE_VERDICT);
        add_test(make_box(mx, mx, mx, mn, mn, mn), 1'b0, VISIBLE_VERDICT);
        add_test(make_box(-50, -50, -50, 50, 50, 50), 1'b0, VISIBLE_VERDICT);
        add_reg(REG_SKIP_NEAR, 1);
        add_test(make_box(-50, -50, -50, 50, 50, 50), 1'b0, VISIBLE_VERDICT);
        // inverted camera box
        add_camera(mx, mn);
        add_test(make_box(0, 0, 0, 0, 0, 0), 1'b1, CAMERA_CULL);
        add_test(make_box(mn, mn, mn, mx, mx, mx), 1'b0, VISIBLE_VERDICT);
    endfunction

    task automatic send_item(input item_t it, input bit typed, input verdict_t typed_v);
        while ($urandom_range(99) < item_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        func <= it.func;
        plane_slot <= it.slot;
        normal_a <= it.a;
        normal_b <= it.b;
        normal_c <= it.c;
        offset_d <= it.d;
        lo_x <= it.box.lo_x;
        lo_y <= it.box.lo_y;
        lo_z <= it.box.lo_z;
        hi_x <= it.box.hi_x;
        hi_y <= it.box.hi_y;
        hi_z <= it.box.hi_z;
        do @(posedge clk); while (item_ready !== 1'b1);
        if (it.func == FUNC_LOAD)
        begin
            if (it.slot < PLANE_COUNT)
            begin
                plane_a[it.slot] = it.a;
                plane_b[it.slot] = it.b;
                plane_c[it.slot] = it.c;
                plane_d[it.slot] = it.d;
            end
        end
        else
        begin
            pending_verdicts.push_back(typed ? typed_v : predict_cull(it.box));
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [COORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        apply_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // loads give no result, so wait out a possible one in flight as well
    task automatic settle_block();
        item_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_camera(input int mnx, input int mny, input int mnz,
                                input int mxx, input int mxy, input int mxz);
        write_reg(REG_VIEW_MIN_X, mnx[COORD_W-1:0]);
        write_reg(REG_VIEW_MIN_Y, mny[COORD_W-1:0]);
        write_reg(REG_VIEW_MIN_Z, mnz[COORD_W-1:0]);
        write_reg(REG_VIEW_MAX_X, mxx[COORD_W-1:0]);
        write_reg(REG_VIEW_MAX_Y, mxy[COORD_W-1:0]);
        write_reg(REG_VIEW_MAX_Z, mxz[COORD_W-1:0]);
    endtask

    task automatic configure_phase(input int phase);
        logic [COORD_W-1:0] junk;
        junk = COORD_W'($urandom);
        case (phase)
            0:
            begin
                write_reg(REG_SKIP_NEAR, {junk[COORD_W-1:1], 1'b0});
                write_reg(REG_UNUSED, COORD_W'($urandom));
                write_camera(int'(COORD_MIN), int'(COORD_MIN), int'(COORD_MIN),
                             int'(COORD_MAX), int'(COORD_MAX), int'(COORD_MAX));
            end
            1:
            begin
                write_reg(REG_SKIP_NEAR, {junk[COORD_W-1:1], 1'b1});
                write_camera(-int'($urandom_range(131072)), -int'($urandom_range(131072)),
                             -int'($urandom_range(131072)), int'($urandom_range(131072)),
                             int'($urandom_range(131072)), int'($urandom_range(131072)));
            end
            default:
            begin
                write_reg(REG_SKIP_NEAR, junk);
                write_camera(int'($urandom_range(5242880)) - 4194304,
                             int'($urandom_range(5242880)) - 4194304,
                             int'($urandom_range(5242880)) - 4194304,
                             int'($urandom_range(5242880)) - 1048576,
                             int'($urandom_range(5242880)) - 1048576,
                             int'($urandom_range(5242880)) - 1048576);
            end
        endcase
    endtask

    // result side: random stalls plus one long hold-off
    initial
    begin : result_sink
        verdict_t want;
        int       seen;
        int       hold_left;
        seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid === 1'b1 && result_ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    report_mismatch("result transaction with no expectation pending");
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (culled !== want.culled)
                    begin
                        report_mismatch($sformatf("culled got %b expected %b",
                                                  culled, want.culled));
                    end
                    if (cull_cause !== want.cause)
                    begin
                        report_mismatch($sformatf("cull_cause got %0d expected %0d",
                                                  cull_cause, want.cause));
                    end
                    if (rejecting_plane !== want.plane)
                    begin
                        report_mismatch($sformatf("rejecting_plane got %0d expected %0d",
                                                  rejecting_plane, want.plane));
                    end
                end
                seen++;
                if (seen == HOLD_AT_RESULT)
                begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0)
            begin
                result_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                result_ready <= ($urandom_range(99) >= result_idle_pct);
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL frustum_box_cull_top");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t row;
        item_t     it;
        int        phase;
        int        count;
        build_directed_table();
        @(posedge rst_n);
        @(posedge clk);
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_REG)
            begin
                settle_block();
                write_reg(row.reg_index, row.reg_data);
            end
            else
            begin
                send_item(row.item, row.typed, row.typed_verdict);
            end
        end
        for (phase = 0; phase < 3; phase++)
        begin
            settle_block();
            configure_phase(phase);
            case (phase)
                0:
                begin
                    item_idle_pct = 35;
                    result_idle_pct = 49;
                end
                1:
                begin
                    item_idle_pct = 49;
                    result_idle_pct = 35;
                end
                default:
                begin
                    item_idle_pct = 0;
                    result_idle_pct = 0;
                end
            endcase
            count = 0;
            while (count < ITEMS_PER_PHASE)
            begin
                it = random_item();
                send_item(it, 1'b0, VISIBLE_VERDICT);
                if (!(it.func == FUNC_LOAD && it.slot >= PLANE_COUNT))
                begin
                    count++;
                end
            end
        end
        item_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASS frustum_box_cull_top");
        end
        else
        begin
            $display("FAIL frustum_box_cull_top");
        end
        $finish;
    end

endmodule

[frustum_box_cull_top.f]
rtl/core/fbc_pkg.sv
rtl/core/fbc_cell.sv
rtl/core/frustum_box_cull_top.sv
sim/frustum_box_cull_top_tb.sv
